// ----- src/f32l_pkg.sv -----
// Package for the FAT32 file loader: item and result types, result kinds
// and the fixed FAT32 constants. Used by the front, back, top and testbench.
`timescale 1ns / 1ps
package f32l_pkg;

   localparam int SECTOR_WORDS    = 128;
   localparam int CLUSTER_SECTORS = 8;
   localparam int WORD_BITS       = $clog2(SECTOR_WORDS);
   localparam int SIC_BITS        = $clog2(CLUSTER_SECTORS);

   localparam logic [31:0] END_OF_CHAIN   = 32'h0FFF_FFF8;
   localparam logic [31:0] FAT_ENTRY_MASK = 32'h0FFF_FFFF;
   localparam logic [31:0] SIZE_LIMIT     = 32'h0100_0000;
   localparam logic [15:0] SECTOR_BYTES   = 16'(SECTOR_WORDS * 4);
   localparam logic [7:0]  CLUSTER_SECTS  = 8'(CLUSTER_SECTORS);

   localparam logic [2:0] K_REQUEST      = 3'd0;
   localparam logic [2:0] K_DATA         = 3'd1;
   localparam logic [2:0] K_DONE         = 3'd2;
   localparam logic [2:0] K_NOT_FOUND    = 3'd3;
   localparam logic [2:0] K_BAD_GEOMETRY = 3'd4;
   localparam logic [2:0] K_TOO_LARGE    = 3'd5;

   localparam logic CSR_NAME_FIRST = 1'b0;
   localparam logic CSR_NAME_LAST  = 1'b1;

   typedef struct packed {
      logic        is_start;
      logic [31:0] word;
   } item_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] value;
      logic        last;
   } res_type;

   typedef struct packed {
      logic       lookup;
      logic [2:0] out_count;
   } back_stat_type;

   // Sector of a cluster: (cluster - 2) * 8 + data_start + sector in cluster.
   function automatic logic [31:0] cluster_sector(input logic [31:0] cluster,
                                                  input logic [SIC_BITS-1:0] sic,
                                                  input logic [31:0] data_start);
      logic [31:0] cm2;
      cm2 = cluster - 32'd2;
      return {cm2[31-SIC_BITS:0], sic} + data_start;
   endfunction

endpackage

// ----- src/f32l_if.sv -----
// Channel interfaces of the FAT32 file loader: request items in, results out.
// Depends on nothing.
`timescale 1ns / 1ps
interface f32l_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [31:0] sector_word;
   modport source (output valid, output func, output sector_word, input ready);
   modport sink   (input valid, input func, input sector_word, output ready);
endinterface

interface f32l_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [31:0] value;
   logic        last;
   modport source (output valid, output kind, output value, output last, input ready);
   modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

// ----- src/f32l_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module f32l_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ----- src/f32l_front.sv -----
// Front end of the FAT32 file loader: accepts request items into a short
// queue and classifies each as a start or a sector word. Uses f32l_pkg.
`timescale 1ns / 1ps
module f32l_front #(
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   f32l_req_if.sink                 req,
   output logic                     out_valid,
   output f32l_pkg::item_type       out_item,
   input  logic                     pop,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   f32l_pkg::item_type q_ff [DEPTH];
   logic [PW-1:0] rp_ff, rp_in, wp_ff, wp_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic push, take;

   assign req.ready = (cnt_ff != CW'(DEPTH));
   assign push      = req.valid && req.ready;
   assign out_valid = (cnt_ff != '0);
   assign out_item  = q_ff[rp_ff];
   assign take      = pop && out_valid;
   assign count     = cnt_ff;

   always_comb begin
      rp_in  = rp_ff;
      wp_in  = wp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (take) begin
         rp_in = (rp_ff == PW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (push && !take) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (take && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff  <= '0;
         wp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rp_ff  <= rp_in;
         wp_ff  <= wp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wp_ff].is_start <= ~req.func;
         q_ff[wp_ff].word     <= req.sector_word;
      end
   end
endmodule

// ----- src/f32l_back.sv -----
// Back end of the FAT32 file loader: the boot, directory, FAT and file
// sequencer, the FAT sector cache and the result queue. Uses f32l_pkg, f32l_ram.
`timescale 1ns / 1ps
module f32l_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  f32l_pkg::item_type        in_item,
   output logic                      in_pop,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [63:0]               csr_wdata,
   f32l_rsp_if.source                rsp,
   output f32l_pkg::back_stat_type   stat
);
   localparam int WB = f32l_pkg::WORD_BITS;
   localparam int SB = f32l_pkg::SIC_BITS;

   typedef enum logic [2:0] {P_IDLE, P_BOOT, P_DIR, P_FAT, P_FILE} phase_type;

   phase_type phase_ff, phase_in;
   logic [WB-1:0] word_ff, word_in;
   logic [SB-1:0] sic_ff, sic_in;
   logic [15:0] fat_start_ff, fat_start_in, bps_ff, bps_in;
   logic [31:0] data_start_ff, data_start_in, fat_size_ff, fat_size_in;
   logic [7:0]  spc_ff, spc_in, copies_ff, copies_in;
   logic [31:0] cc_ff, cc_in, ecl_ff, ecl_in, esz_ff, esz_in;
   logic [31:0] cached_ff, cached_in, cand_ff, cand_in, bypv_ff, bypv_in;
   logic match_ff, match_in, nsf_ff, nsf_in, cif_ff, cif_in;
   logic cvalid_ff, cvalid_in, lk_ff, lk_in, byp_ff, byp_in;
   logic [63:0] name8_ff;
   logic [23:0] name3_ff;

   f32l_pkg::res_type oq_ff [4];
   logic [1:0] rp_ff, wp_ff;
   logic [2:0] cnt_ff;

   logic ram_we;
   logic [WB-1:0] ram_waddr, ram_raddr;
   logic [31:0] ram_rdata, v, fsec, adv_next;
   logic a_v, b_v, do_adv, do_nxt, out_take, is_end;
   f32l_pkg::res_type a, b, first;

   f32l_ram #(.WIDTH(32), .DEPTH(f32l_pkg::SECTOR_WORDS)) u_cache (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (v),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign v         = in_item.word;
   assign ram_waddr = word_ff;
   assign ram_raddr = cc_ff[WB-1:0];
   assign rsp.valid = (cnt_ff != 3'd0);
   assign rsp.kind  = oq_ff[rp_ff].kind;
   assign rsp.value = oq_ff[rp_ff].value;
   assign rsp.last  = oq_ff[rp_ff].last;
   assign out_take  = rsp.valid && rsp.ready;
   assign stat.lookup    = lk_ff;
   assign stat.out_count = cnt_ff;

   always_comb begin
      phase_in = phase_ff; word_in = word_ff; sic_in = sic_ff;
      fat_start_in = fat_start_ff; bps_in = bps_ff; data_start_in = data_start_ff;
      fat_size_in = fat_size_ff; spc_in = spc_ff; copies_in = copies_ff;
      cc_in = cc_ff; ecl_in = ecl_ff; esz_in = esz_ff; cached_in = cached_ff;
      cand_in = cand_ff; bypv_in = bypv_ff; match_in = match_ff; nsf_in = nsf_ff;
      cif_in = cif_ff; cvalid_in = cvalid_ff; lk_in = 1'b0; byp_in = byp_ff;
      ram_we = 1'b0; in_pop = 1'b0; do_adv = 1'b0; do_nxt = 1'b0;
      adv_next = '0; fsec = '0; a_v = 1'b0; b_v = 1'b0; a = '0; b = '0;
      is_end = (word_ff == WB'(f32l_pkg::SECTOR_WORDS - 1));

      if (lk_ff) begin
         // Cache read issued last cycle; the bypass covers the word written then.
         do_adv   = 1'b1;
         adv_next = (byp_ff ? bypv_ff : ram_rdata) & f32l_pkg::FAT_ENTRY_MASK;
      end else if (in_valid && cnt_ff <= 3'd2) begin
         in_pop = 1'b1;
         if (in_item.is_start) begin
            if (phase_ff == P_FAT) begin
               cvalid_in = 1'b0;
            end
            phase_in = P_BOOT; sic_in = '0; match_in = 1'b0; nsf_in = 1'b0;
            cif_in = 1'b0; word_in = '0;
            a_v = 1'b1; a.kind = f32l_pkg::K_REQUEST; a.value = '0;
         end else if (phase_ff != P_IDLE) begin
            word_in = word_ff + 1'b1;
            case (phase_ff)
               P_BOOT: begin
                  case (word_ff)
                     WB'(2): bps_in[7:0] = v[31:24];
                     WB'(3): begin
                        bps_in[15:8] = v[7:0];
                        spc_in = v[15:8];
                        fat_start_in = v[31:16];
                     end
                     WB'(4): copies_in = v[7:0];
                     WB'(9): fat_size_in = v;
                     WB'(10): data_start_in = {16'b0, fat_start_ff}
                                              + fat_size_ff * {24'b0, copies_ff};
                     WB'(11): cc_in = v;
                     default: ;
                  endcase
                  if (is_end) begin
                     if (bps_ff != f32l_pkg::SECTOR_BYTES ||
                         spc_ff != f32l_pkg::CLUSTER_SECTS) begin
                        phase_in = P_IDLE;
                        a_v = 1'b1; a.kind = f32l_pkg::K_BAD_GEOMETRY;
                     end else begin
                        cif_in = 1'b0; do_adv = 1'b1; adv_next = cc_ff;
                     end
                  end
               end
               P_DIR: begin
                  if (!match_ff) begin
                     case (word_ff[2:0])
                        3'd0: nsf_in = (v == name8_ff[31:0]);
                        3'd1: nsf_in = nsf_ff && (v == name8_ff[63:32]);
                        3'd2: nsf_in = nsf_ff && (v[23:0] == name3_ff);
                        3'd5: cand_in = {v[15:0], 16'b0};
                        3'd6: cand_in = cand_ff | {16'b0, v[31:16]};
                        3'd7: begin
                           if (nsf_ff) begin
                              match_in = 1'b1; ecl_in = cand_ff; esz_in = v;
                           end
                        end
                        default: ;
                     endcase
                  end
                  if (is_end) begin
                     if (match_in) begin
                        if (esz_in > f32l_pkg::SIZE_LIMIT) begin
                           phase_in = P_IDLE;
                           a_v = 1'b1; a.kind = f32l_pkg::K_TOO_LARGE;
                        end else if (ecl_in == '0) begin
                           phase_in = P_IDLE;
                           a_v = 1'b1; a.kind = f32l_pkg::K_DONE;
                        end else begin
                           cif_in = 1'b1; do_adv = 1'b1; adv_next = ecl_in;
                        end
                     end else begin
                        do_nxt = 1'b1;
                     end
                  end
               end
               P_FAT: begin
                  ram_we = 1'b1;
                  if (is_end) begin
                     cvalid_in = 1'b1; lk_in = 1'b1;
                     byp_in  = (cc_ff[WB-1:0] == word_ff);
                     bypv_in = v;
                  end
               end
               P_FILE: begin
                  a_v = 1'b1; a.kind = f32l_pkg::K_DATA; a.value = v;
                  if (is_end) begin
                     do_nxt = 1'b1;
                  end
               end
               default: phase_in = P_IDLE;
            endcase
         end
      end

      if (do_nxt) begin
         if (sic_ff != SB'(f32l_pkg::CLUSTER_SECTORS - 1)) begin
            sic_in = sic_ff + 1'b1;
            b_v = 1'b1; b.kind = f32l_pkg::K_REQUEST;
            b.value = f32l_pkg::cluster_sector(cc_ff, sic_in, data_start_ff);
         end else begin
            fsec = {16'b0, fat_start_ff} + {7'b0, cc_ff[31:WB]};
            if (cvalid_ff && cached_ff == fsec) begin
               lk_in = 1'b1; byp_in = 1'b0;
            end else begin
               cvalid_in = 1'b0; cached_in = fsec; phase_in = P_FAT; word_in = '0;
               b_v = 1'b1; b.kind = f32l_pkg::K_REQUEST; b.value = fsec;
            end
         end
      end

      if (do_adv) begin
         cc_in = adv_next;
         b_v = 1'b1;
         if (adv_next >= f32l_pkg::END_OF_CHAIN) begin
            phase_in = P_IDLE;
            b.kind = cif_in ? f32l_pkg::K_DONE : f32l_pkg::K_NOT_FOUND;
         end else begin
            sic_in = '0; nsf_in = 1'b0; word_in = '0;
            phase_in = cif_in ? P_FILE : P_DIR;
            b.kind = f32l_pkg::K_REQUEST;
            b.value = f32l_pkg::cluster_sector(adv_next, '0, data_start_ff);
         end
      end

      // The final result of an item waits for any pending cache lookup.
      b.last = 1'b1;
      a.last = !b_v && !lk_in;
      first  = a_v ? a : b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE; word_ff <= '0; sic_ff <= '0;
         fat_start_ff <= '0; bps_ff <= '0; data_start_ff <= '0;
         fat_size_ff <= '0; spc_ff <= '0; copies_ff <= '0;
         cc_ff <= '0; ecl_ff <= '0; esz_ff <= '0; cached_ff <= '0;
         cand_ff <= '0; bypv_ff <= '0; match_ff <= 1'b0; nsf_ff <= 1'b0;
         cif_ff <= 1'b0; cvalid_ff <= 1'b0; lk_ff <= 1'b0; byp_ff <= 1'b0;
         name8_ff <= '0; name3_ff <= '0;
         rp_ff <= '0; wp_ff <= '0; cnt_ff <= '0;
      end else begin
         phase_ff <= phase_in; word_ff <= word_in; sic_ff <= sic_in;
         fat_start_ff <= fat_start_in; bps_ff <= bps_in; data_start_ff <= data_start_in;
         fat_size_ff <= fat_size_in; spc_ff <= spc_in; copies_ff <= copies_in;
         cc_ff <= cc_in; ecl_ff <= ecl_in; esz_ff <= esz_in; cached_ff <= cached_in;
         cand_ff <= cand_in; bypv_ff <= bypv_in; match_ff <= match_in; nsf_ff <= nsf_in;
         cif_ff <= cif_in; cvalid_ff <= cvalid_in; lk_ff <= lk_in; byp_ff <= byp_in;
         if (csr_we) begin
            if (csr_index == f32l_pkg::CSR_NAME_FIRST) begin
               name8_ff <= csr_wdata;
            end else begin
               name3_ff <= csr_wdata[23:0];
            end
         end
         if (out_take) begin
            rp_ff <= rp_ff + 1'b1;
         end
         wp_ff  <= wp_ff + {1'b0, a_v} + {1'b0, b_v};
         cnt_ff <= cnt_ff + {2'b0, a_v} + {2'b0, b_v} - {2'b0, out_take};
      end
      if (a_v || b_v) begin
         oq_ff[wp_ff] <= first;
      end
      if (a_v && b_v) begin
         oq_ff[wp_ff + 2'd1] <= b;
      end
   end
endmodule

// ----- src/fat32_file_loader.sv -----
// Top level of the FAT32 file loader: front queue, back sequencer, assertions.
// Uses f32l_pkg, f32l_if, f32l_front, f32l_back.
`timescale 1ns / 1ps
// Usage: set the 11-byte short name through the csr_ write port (index 0 holds
// bytes 0 to 7, index 1 bytes 8 to 10) while the block is idle. A start item
// (func 0) on req_ch yields a request for sector 0; the source then sends the
// 128 words of each requested sector as func 1 items. Results leave on rsp_ch:
// sector requests, file data words, then one of done, not found, bad geometry
// or too large; last marks the final result of each item.
// Throughput is one item per cycle while the back end takes items. An item
// accepted on req_ch waits in the front queue until the back end takes it
// and writes its results into the result queue. A read of a cluster's FAT
// entry from the one-sector FAT cache (a hit, or the end of a FAT sector
// read) holds off the next item. The back end takes an item only while the
// four-entry result queue has two free places, so a stalled receiver fills
// the result queue and then the front queue, and req_ch.ready drops. Reset
// clears all control state and the cache valid flag, not the cache RAM.
module fat32_file_loader #(
   parameter int IN_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   f32l_req_if.sink    req_ch,
   f32l_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);
   logic                       item_valid, item_pop;
   f32l_pkg::item_type         item;
   logic [$clog2(IN_DEPTH+1)-1:0] front_count;
   f32l_pkg::back_stat_type    stat;

   f32l_front #(.DEPTH(IN_DEPTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .out_valid (item_valid),
      .out_item  (item),
      .pop       (item_pop),
      .count     (front_count)
   );

   f32l_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (item_valid),
      .in_item   (item),
      .in_pop    (item_pop),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp       (rsp_ch),
      .stat      (stat)
   );

   a_out_bound: assert property (@(posedge clock) disable iff (reset)
      stat.out_count <= 3'd4)
      else $error("result queue overflow");

   a_lookup_one: assert property (@(posedge clock) disable iff (reset)
      stat.lookup |=> !stat.lookup)
      else $error("cache lookup lasted more than one cycle");

   a_no_pop_in_lookup: assert property (@(posedge clock) disable iff (reset)
      stat.lookup |-> !item_pop)
      else $error("item taken during cache lookup");

   a_full_not_ready: assert property (@(posedge clock) disable iff (reset)
      (front_count == ($clog2(IN_DEPTH+1))'(IN_DEPTH)) |-> !req_ch.ready)
      else $error("front queue ready while full");
endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the FAT32 file loader: builds disk images on the fly,
// predicts every result in a local model and checks it. Uses f32l_pkg and f32l_if.
`timescale 1ns / 1ps
module testbench;

   localparam int LIMIT_CYCLES = 2000000;
   localparam int MAX_LOAD_SECTORS = 40;

   typedef enum logic [2:0] {PH_IDLE, PH_BOOT, PH_DIR, PH_FAT, PH_FILE} load_phase_type;
   typedef enum int {ENT_MATCH, ENT_NEAR_LO, ENT_NEAR_HI, ENT_OTHER} entry_kind_type;
   typedef enum int {GEO_GOOD, GEO_BAD, GEO_MIXED} geo_sel_type;
   typedef enum int {ROOT_SMALL, ROOT_END, ROOT_MIXED} root_sel_type;
   typedef enum int {SZ_MIXED, SZ_HUGE, SZ_EMPTY, SZ_SMALL} size_sel_type;

   typedef struct packed {
      logic        func;
      logic [31:0] word;
   } sector_item_type;

   logic clock;
   logic reset;
   logic        csr_we;
   logic        csr_index;
   logic [63:0] csr_wdata;

   f32l_req_if req_ch();
   f32l_rsp_if rsp_ch();

   fat32_file_loader u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sector_item_type        pending_words[$];
   f32l_pkg::res_type      expected_results[$];
   int  errors;
   int  cycles;
   int  loaded_items;
   bit  burst_mode;
   bit  stall_arm;
   bit  stall_used;
   int  stall_left;
   int  send_gap;
   int  recv_gap;
   int  next_gap;
   sector_item_type        next_item;
   f32l_pkg::res_type      expected_now;

   // Local copy of the loader state.
   logic [63:0]  name_first;
   logic [23:0]  name_last;
   load_phase_type ph;
   int           widx;
   int           sic;
   logic [15:0]  fat_start;
   logic [31:0]  data_start;
   logic [7:0]   spc;
   logic [15:0]  bps;
   logic [7:0]   copies;
   logic [31:0]  fat_size;
   logic [31:0]  cur_cluster;
   bit           entry_hit;
   logic [31:0]  entry_cluster;
   logic [31:0]  entry_size;
   logic [31:0]  cached_sector;
   bit           cache_ok;
   logic [31:0]  fat_cache [f32l_pkg::SECTOR_WORDS];
   bit           is_file;
   bit           name_ok;
   logic [31:0]  cand_cluster;

   // Disk image choices for the load being generated.
   int           geo_sel;
   int           root_sel;
   int           match_pct;
   int           size_sel;
   bit           boot_good;
   bit           bad_bps;
   logic [15:0]  img_fat_start;
   logic [7:0]   img_copies;
   logic [31:0]  img_fat_size;
   logic [31:0]  img_root;
   entry_kind_type ent_kind;
   logic [31:0]  ent_cluster;
   logic [31:0]  ent_size;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void add_result(logic [2:0] kind, logic [31:0] value);
      f32l_pkg::res_type r;
      r.kind = kind;
      r.value = value;
      r.last = 1'b0;
      expected_results.push_back(r);
   endfunction

   function automatic void request_sector(logic [31:0] s);
      widx = 0;
      add_result(f32l_pkg::K_REQUEST, s);
   endfunction

   function automatic void request_cluster_sector();
      request_sector((cur_cluster - 32'd2) * 32'd8 + data_start + 32'(sic));
   endfunction

   function automatic void advance_chain(logic [31:0] nxt);
      cur_cluster = nxt;
      if (nxt >= f32l_pkg::END_OF_CHAIN) begin
         ph = PH_IDLE;
         add_result(is_file ? f32l_pkg::K_DONE : f32l_pkg::K_NOT_FOUND, 32'd0);
      end else begin
         sic = 0;
         name_ok = 0;
         ph = is_file ? PH_FILE : PH_DIR;
         request_cluster_sector();
      end
   endfunction

   function automatic void follow_chain();
      logic [31:0] s;
      s = {16'd0, fat_start} + (cur_cluster >> 7);
      if (cache_ok && cached_sector == s) begin
         advance_chain(fat_cache[cur_cluster[6:0]] & f32l_pkg::FAT_ENTRY_MASK);
      end else begin
         cache_ok = 0;
         cached_sector = s;
         ph = PH_FAT;
         request_sector(s);
      end
   endfunction

   function automatic void next_sector_or_follow();
      sic++;
      if (sic < f32l_pkg::CLUSTER_SECTORS) request_cluster_sector();
      else follow_chain();
   endfunction

   function automatic void predict_results(logic f, logic [31:0] v);
      int base;
      int w;
      bit fin;
      base = expected_results.size();
      w = widx % f32l_pkg::SECTOR_WORDS;
      if (!f) begin
         // A start abandons any load, and a half-read FAT sector is dropped.
         if (ph == PH_FAT) cache_ok = 0;
         ph = PH_BOOT;
         sic = 0;
         entry_hit = 0;
         name_ok = 0;
         is_file = 0;
         request_sector(32'd0);
      end else if (ph != PH_IDLE) begin
         fin = (w == f32l_pkg::SECTOR_WORDS - 1);
         widx = w + 1;
         case (ph)
            PH_BOOT: begin
               case (w)
                  2: bps = {bps[15:8], v[31:24]};
                  3: begin
                     bps = {v[7:0], bps[7:0]};
                     spc = v[15:8];
                     fat_start = v[31:16];
                  end
                  4: copies = v[7:0];
                  9: fat_size = v;
                  11: cur_cluster = v;
                  default: ;
               endcase
               if (fin) begin
                  data_start = {16'd0, fat_start} + fat_size * {24'd0, copies};
                  if (bps != f32l_pkg::SECTOR_BYTES || spc != f32l_pkg::CLUSTER_SECTS) begin
                     ph = PH_IDLE;
                     add_result(f32l_pkg::K_BAD_GEOMETRY, 32'd0);
                  end else begin
                     is_file = 0;
                     advance_chain(cur_cluster);
                  end
               end
            end
            PH_DIR: begin
               if (!entry_hit) begin
                  case (w % 8)
                     0: name_ok = (v == name_first[31:0]);
                     1: name_ok = name_ok && (v == name_first[63:32]);
                     2: name_ok = name_ok && (v[23:0] == name_last);
                     5: cand_cluster = {v[15:0], 16'd0};
                     6: cand_cluster = cand_cluster | {16'd0, v[31:16]};
                     7: if (name_ok) begin
                        entry_hit = 1;
                        entry_cluster = cand_cluster;
                        entry_size = v;
                     end
                     default: ;
                  endcase
               end
               if (fin) begin
                  if (entry_hit) begin
                     if (entry_size > f32l_pkg::SIZE_LIMIT) begin
                        ph = PH_IDLE;
                        add_result(f32l_pkg::K_TOO_LARGE, 32'd0);
                     end else if (entry_cluster == 32'd0) begin
                        ph = PH_IDLE;
                        add_result(f32l_pkg::K_DONE, 32'd0);
                     end else begin
                        is_file = 1;
                        advance_chain(entry_cluster);
                     end
                  end else begin
                     next_sector_or_follow();
                  end
               end
            end
            PH_FAT: begin
               fat_cache[w] = v;
               if (fin) begin
                  cache_ok = 1;
                  advance_chain(fat_cache[cur_cluster[6:0]] & f32l_pkg::FAT_ENTRY_MASK);
               end
            end
            PH_FILE: begin
               add_result(f32l_pkg::K_DATA, v);
               if (fin) next_sector_or_follow();
            end
            default: ph = PH_IDLE;
         endcase
      end
      if (expected_results.size() > base)
         expected_results[expected_results.size() - 1].last = 1'b1;
   endfunction

   task automatic send_item(logic f, logic [31:0] w);
      sector_item_type it;
      it.func = f;
      it.word = w;
      if (!(f && ph == PH_IDLE)) loaded_items++;
      pending_words.push_back(it);
      predict_results(f, w);
   endtask

   function automatic logic [31:0] small_cluster();
      return 32'($urandom_range(2, 300));
   endfunction

   function automatic logic [31:0] end_marker();
      logic [31:0] e;
      e = f32l_pkg::END_OF_CHAIN + 32'($urandom_range(0, 7));
      e[31:28] = 4'($urandom);
      return e;
   endfunction

   // Produces the next sector word of the disk image for the current phase.
   function automatic logic [31:0] image_word();
      logic [31:0] w;
      int r;
      w = $urandom;
      case (ph)
         PH_BOOT: begin
            if (widx == 0) begin
               boot_good = (geo_sel == GEO_GOOD) ||
                           (geo_sel == GEO_MIXED && $urandom_range(0, 5) != 0);
               bad_bps = $urandom_range(0, 1);
               img_fat_start = 16'($urandom);
               img_copies = ($urandom_range(0, 7) == 0) ? 8'($urandom) :
                            8'($urandom_range(0, 2));
               img_fat_size = ($urandom_range(0, 3) == 0) ? $urandom :
                              32'($urandom_range(0, 5000));
               r = $urandom_range(0, 9);
               if (root_sel == ROOT_END || (root_sel == ROOT_MIXED && r == 0))
                  img_root = ($urandom_range(0, 1) != 0) ? end_marker() : 32'hFFFF_FFFF;
               else if (root_sel == ROOT_MIXED && r == 1)
                  img_root = 32'($urandom_range(0, 1));
               else
                  img_root = small_cluster();
            end
            case (widx)
               2: w[31:24] = (boot_good || !bad_bps) ? 8'h00 : 8'($urandom_range(1, 255));
               3: begin
                  w[7:0] = (boot_good || !bad_bps) ? 8'h02 : 8'h04;
                  w[15:8] = (boot_good || bad_bps) ? f32l_pkg::CLUSTER_SECTS :
                            8'($urandom_range(0, 7));
                  w[31:16] = img_fat_start;
               end
               4: w[7:0] = img_copies;
               9: w = img_fat_size;
               11: w = img_root;
               default: ;
            endcase
         end
         PH_DIR: begin
            if (widx % 8 == 0) begin
               r = $urandom_range(0, 99);
               if (r < match_pct) ent_kind = ENT_MATCH;
               else if (r < match_pct + 15) ent_kind = ENT_NEAR_LO;
               else if (r < match_pct + 30) ent_kind = ENT_NEAR_HI;
               else ent_kind = ENT_OTHER;
               r = (size_sel == SZ_MIXED) ? $urandom_range(0, 11) : 99;
               ent_cluster = small_cluster();
               ent_size = 32'($urandom_range(0, 100000));
               if (size_sel == SZ_HUGE || r == 0)
                  ent_size = f32l_pkg::SIZE_LIMIT + 32'd1 + $urandom;
               if (r == 1) ent_size = f32l_pkg::SIZE_LIMIT;
               if (size_sel == SZ_EMPTY || r == 2 || r == 3) ent_cluster = 32'd0;
               if (r == 4) ent_cluster = end_marker();
               if (ent_size < f32l_pkg::SIZE_LIMIT && ent_size[31]) ent_size = 32'd0;
            end
            case (widx % 8)
               0: if (ent_kind != ENT_OTHER) w = name_first[31:0];
               1: if (ent_kind == ENT_MATCH || ent_kind == ENT_NEAR_HI)
                     w = name_first[63:32];
                  else if (ent_kind == ENT_NEAR_LO)
                     w = name_first[63:32] ^ ($urandom | 32'd1);
               2: if (ent_kind == ENT_MATCH)
                     w[23:0] = name_last;
                  else if (ent_kind == ENT_NEAR_HI)
                     w[23:0] = name_last ^ (24'($urandom) | 24'd1);
               5: w[15:0] = ent_cluster[31:16];
               6: w[31:16] = ent_cluster[15:0];
               7: w = ent_size;
               default: ;
            endcase
         end
         PH_FAT: begin
            if ($urandom_range(0, 99) < 55) w = end_marker();
            else begin
               w = small_cluster();
               w[31:28] = 4'($urandom);
            end
         end
         default: ;
      endcase
      return w;
   endfunction

   task automatic load_file(int geo, int root, int pct, int sz);
      int sectors;
      geo_sel = geo;
      root_sel = root;
      match_pct = pct;
      size_sel = sz;
      sectors = 0;
      send_item(1'b0, $urandom);
      while (ph != PH_IDLE) begin
         if (widx % f32l_pkg::SECTOR_WORDS == 0) sectors++;
         if (sectors > MAX_LOAD_SECTORS) begin
            // Long chains are cut short by a restart that ends on bad geometry.
            geo_sel = GEO_BAD;
            sectors = -1000000;
            send_item(1'b0, $urandom);
         end else if ($urandom_range(0, 999) == 0) begin
            send_item(1'b0, $urandom);
         end else begin
            send_item(1'b1, image_word());
         end
      end
      if ($urandom_range(0, 7) == 0) send_item(1'b1, $urandom);
   endtask

   task automatic write_name(logic [63:0] first, logic [63:0] last3);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= f32l_pkg::CSR_NAME_FIRST;
      csr_wdata <= first;
      @(posedge clock);
      csr_index <= f32l_pkg::CSR_NAME_LAST;
      csr_wdata <= last3;
      @(posedge clock);
      csr_we <= 1'b0;
      name_first = first;
      name_last = last3[23:0];
   endtask

   task automatic wait_idle();
      while (pending_words.size() > 0 || req_ch.valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic random_loads(int target);
      while (loaded_items < target)
         load_file(GEO_MIXED, ROOT_MIXED, $urandom_range(0, 2) * 4, SZ_MIXED);
   endtask

   function automatic void report_mismatch(f32l_pkg::res_type e, bit have_e);
      errors++;
      if (errors <= 10) begin
         if (have_e)
            $display("mismatch: expected kind %0d value %h last %0b, %s %0d value %h last %0b",
                     e.kind, e.value, e.last, "got kind",
                     rsp_ch.kind, rsp_ch.value, rsp_ch.last);
         else
            $display("unexpected result: kind %0d value %h last %0b",
                     rsp_ch.kind, rsp_ch.value, rsp_ch.last);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.func <= 1'b0;
         req_ch.sector_word <= 32'd0;
         send_gap <= 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (send_gap > 0) begin
            req_ch.valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_words.size() > 0) begin
            next_item = pending_words.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.func <= next_item.func;
            req_ch.sector_word <= next_item.word;
            send_gap <= burst_mode ? 0 : $urandom_range(0, 12);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // The one long receiver stall is timed here, apart from the result checker.
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
         stall_used <= 1'b0;
      end else if (stall_arm && !stall_used) begin
         stall_left <= 400;
         stall_used <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap <= 0;
      end else begin
         next_gap = recv_gap;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch(expected_now, 1'b0);
            end else begin
               expected_now = expected_results.pop_front();
               if (rsp_ch.kind != expected_now.kind || rsp_ch.value != expected_now.value ||
                   rsp_ch.last != expected_now.last)
                  report_mismatch(expected_now, 1'b1);
            end
            next_gap = burst_mode ? 0 : $urandom_range(0, 12);
         end else if (next_gap > 0) begin
            next_gap = next_gap - 1;
         end
         recv_gap <= next_gap;
         rsp_ch.ready <= (next_gap == 0) && (stall_left == 0);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = f32l_pkg::CSR_NAME_FIRST;
      csr_wdata = 64'd0;
      req_ch.valid = 1'b0;
      req_ch.func = 1'b0;
      req_ch.sector_word = 32'd0;
      rsp_ch.ready = 1'b0;
      errors = 0;
      cycles = 0;
      loaded_items = 0;
      burst_mode = 1'b0;
      stall_arm = 1'b0;
      ph = PH_IDLE;
      widx = 0;
      sic = 0;
      fat_start = '0;
      data_start = '0;
      spc = '0;
      bps = '0;
      copies = '0;
      fat_size = '0;
      cur_cluster = '0;
      entry_hit = 0;
      entry_cluster = '0;
      entry_size = '0;
      cached_sector = '0;
      cache_ok = 0;
      is_file = 0;
      name_ok = 0;
      cand_cluster = '0;
      name_first = '0;
      name_last = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: all-zero name, idle word, restart during boot, then each outcome.
      write_name(64'd0, 64'd0);
      send_item(1'b1, 32'hFFFF_FFFF);
      send_item(1'b0, 32'd0);
      send_item(1'b0, 32'hFFFF_FFFF);
      load_file(GEO_BAD, ROOT_SMALL, 0, SZ_SMALL);
      load_file(GEO_GOOD, ROOT_END, 0, SZ_SMALL);
      load_file(GEO_GOOD, ROOT_SMALL, 100, SZ_HUGE);
      load_file(GEO_GOOD, ROOT_SMALL, 100, SZ_EMPTY);
      load_file(GEO_GOOD, ROOT_SMALL, 100, SZ_SMALL);
      wait_idle();

      // All-ones name with no idling and one long receiver stall.
      write_name(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      burst_mode = 1'b1;
      stall_arm = 1'b1;
      load_file(GEO_GOOD, ROOT_SMALL, 0, SZ_SMALL);
      random_loads(loaded_items + 300);
      wait_idle();
      burst_mode = 1'b0;

      write_name({$urandom, $urandom}, {32'd0, $urandom});
      random_loads(loaded_items + 450);
      wait_idle();

      write_name({$urandom, $urandom}, {$urandom, $urandom});
      random_loads(loaded_items + 400);
      wait_idle();

      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
